@@ src/ppmfd_pkg.sv @@
// Shared types, constants and decode helpers for the PPM frame decoder.
package ppmfd_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 6;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned SLOT_W    = 3;
  localparam int unsigned MODE_W    = 2;

  localparam logic [COUNT_W-1:0] SYNC_MAX = '1;

  localparam logic [LEVEL_W-1:0] SYNC_GAP_RST   = 16'd4000;
  localparam logic [COUNT_W-1:0] READY_CNT_RST  = 8'd4;
  localparam logic [LEVEL_W-1:0] MODE_HIGH_RST  = 16'd1800;
  localparam logic [LEVEL_W-1:0] MODE_LOW_RST   = 16'd1200;
  localparam logic [LEVEL_W-1:0] SWITCH_LVL_RST = 16'd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_GAP    = 3'd0,
    CFG_READY_COUNT = 3'd1,
    CFG_MODE_HIGH   = 3'd2,
    CFG_MODE_LOW    = 3'd3,
    CFG_SWITCH_LVL  = 3'd4
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_DISARMED = 2'd0,
    MODE_ANGLE    = 2'd1,
    MODE_ACRO     = 2'd2
  } mode_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] sync_gap;
    logic [COUNT_W-1:0] ready_count;
    logic [LEVEL_W-1:0] mode_high;
    logic [LEVEL_W-1:0] mode_low;
    logic [LEVEL_W-1:0] switch_lvl;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] pulse_gap;
    logic [SLOT_W-1:0] slot_index;
    logic              slot_written;
    logic              frame_sync;
    logic              ready;
  } frame_res_t;

  function automatic mode_e decode_mode(logic [TIME_W-1:0] w, logic [LEVEL_W-1:0] high,
                                        logic [LEVEL_W-1:0] low);
    mode_e m;
    if (w > {{(TIME_W-LEVEL_W){1'b0}}, high}) begin
      m = MODE_DISARMED;
    end else if (w < {{(TIME_W-LEVEL_W){1'b0}}, low}) begin
      m = MODE_ANGLE;
    end else begin
      m = MODE_ACRO;
    end
    return m;
  endfunction

endpackage

@@ src/ppmfd_cfg_regs.sv @@
// Configuration register file for the PPM frame decoder.
module ppmfd_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ppmfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ppmfd_pkg::CFG_DAT_W-1:0]  cfg_wdata_i,
  output ppmfd_pkg::cfg_t                  cfg_o
);

  ppmfd_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ppmfd_pkg::cfg_idx_e'(cfg_idx_i))
        ppmfd_pkg::CFG_SYNC_GAP:    cfg_d.sync_gap    = cfg_wdata_i;
        ppmfd_pkg::CFG_READY_COUNT: cfg_d.ready_count = cfg_wdata_i[ppmfd_pkg::COUNT_W-1:0];
        ppmfd_pkg::CFG_MODE_HIGH:   cfg_d.mode_high   = cfg_wdata_i;
        ppmfd_pkg::CFG_MODE_LOW:    cfg_d.mode_low    = cfg_wdata_i;
        ppmfd_pkg::CFG_SWITCH_LVL:  cfg_d.switch_lvl  = cfg_wdata_i;
        default: ; // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_gap    <= ppmfd_pkg::SYNC_GAP_RST;
      cfg_q.ready_count <= ppmfd_pkg::READY_CNT_RST;
      cfg_q.mode_high   <= ppmfd_pkg::MODE_HIGH_RST;
      cfg_q.mode_low    <= ppmfd_pkg::MODE_LOW_RST;
      cfg_q.switch_lvl  <= ppmfd_pkg::SWITCH_LVL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/ppmfd_frame_core.sv @@
// Frame state tracker: gap, sync detection, slot pointer and channel widths.
module ppmfd_frame_core #(
  parameter int unsigned NUM_CHANNELS = ppmfd_pkg::NUM_CHANNELS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [ppmfd_pkg::TIME_W-1:0]    edge_time_i,
  input  ppmfd_pkg::cfg_t                 cfg_i,
  output ppmfd_pkg::frame_res_t           res_o,
  output logic [ppmfd_pkg::TIME_W-1:0]    ch_mode_o,
  output logic [ppmfd_pkg::TIME_W-1:0]    ch_switch_o
);

  localparam int unsigned PtrW = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned IdxW = $clog2(NUM_CHANNELS);
  localparam int unsigned ModeCh   = 4;
  localparam int unsigned SwitchCh = 5;

  logic [ppmfd_pkg::TIME_W-1:0]  last_edge_q, last_edge_d;
  logic [PtrW-1:0]               next_slot_q, next_slot_d;
  logic [ppmfd_pkg::COUNT_W-1:0] sync_seen_q, sync_seen_d;
  logic                          ready_q, ready_d;
  logic [ppmfd_pkg::TIME_W-1:0]  ch_q [NUM_CHANNELS];

  logic [ppmfd_pkg::TIME_W-1:0]  gap;
  logic                          is_sync, written;
  logic [IdxW-1:0]               wr_idx;

  assign gap     = edge_time_i - last_edge_q;
  assign is_sync = gap >= {{(ppmfd_pkg::TIME_W-ppmfd_pkg::LEVEL_W){1'b0}}, cfg_i.sync_gap};
  assign written = !is_sync && (sync_seen_q != '0) && (next_slot_q < PtrW'(NUM_CHANNELS));
  assign wr_idx  = next_slot_q[IdxW-1:0];

  always_comb begin
    last_edge_d = last_edge_q;
    next_slot_d = next_slot_q;
    sync_seen_d = sync_seen_q;
    ready_d     = ready_q;
    if (step_i) begin
      last_edge_d = edge_time_i;
      if (is_sync) begin
        next_slot_d = '0;
        if (sync_seen_q >= cfg_i.ready_count) ready_d = 1'b1;
        if (sync_seen_q != ppmfd_pkg::SYNC_MAX) sync_seen_d = sync_seen_q + 1'b1;
      end else if (written) begin
        next_slot_d = next_slot_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q <= '0;
      next_slot_q <= '0;
      sync_seen_q <= '0;
      ready_q     <= 1'b0;
    end else begin
      last_edge_q <= last_edge_d;
      next_slot_q <= next_slot_d;
      sync_seen_q <= sync_seen_d;
      ready_q     <= ready_d;
    end
  end

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_ch
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ch_q[g] <= '0;
      end else if (step_i && written && (wr_idx == IdxW'(g))) begin
        ch_q[g] <= gap;
      end
    end
  end

  // Decoders see the channel values after this edge, so forward the write.
  assign ch_mode_o   = (written && wr_idx == IdxW'(ModeCh))   ? gap : ch_q[ModeCh];
  assign ch_switch_o = (written && wr_idx == IdxW'(SwitchCh)) ? gap : ch_q[SwitchCh];

  assign res_o.pulse_gap    = gap;
  assign res_o.slot_index   = written ? next_slot_q[ppmfd_pkg::SLOT_W-1:0] : '0;
  assign res_o.slot_written = written;
  assign res_o.frame_sync   = is_sync;
  assign res_o.ready        = ready_d;

endmodule

@@ src/ppmfd_chan_decode.sv @@
// Flying mode and switch decode from the mode and switch channel widths.
module ppmfd_chan_decode (
  input  logic [ppmfd_pkg::TIME_W-1:0]  ch_mode_i,
  input  logic [ppmfd_pkg::TIME_W-1:0]  ch_switch_i,
  input  ppmfd_pkg::cfg_t               cfg_i,
  output ppmfd_pkg::mode_e              mode_o,
  output logic                          switch_high_o
);

  assign mode_o = ppmfd_pkg::decode_mode(ch_mode_i, cfg_i.mode_high, cfg_i.mode_low);
  assign switch_high_o =
    ch_switch_i > {{(ppmfd_pkg::TIME_W-ppmfd_pkg::LEVEL_W){1'b0}}, cfg_i.switch_lvl};

endmodule

@@ src/ppm_frame_decoder_unit.sv @@
// Top level of the PPM frame decoder: input register, decode logic, result register.
//
// Usage:
//  - Input channel: in_valid_i / in_stall_o carry one request per rising edge
//    of the PPM line, edge_time_i being its free-running microsecond stamp.
//  - Output channel: out_valid_o / out_stall_i carry one result per request:
//    gap, slot index, slot written, sync and ready flags, flying mode, switch state.
//  - Config: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//    (0 sync gap, 1 ready count, 2 mode high, 3 mode low, 4 switch level);
//    other indexes are ignored. Write only while no request is in flight.
//  - Path: a request is accepted into the input register; its result then
//    moves to the result register and is held there until it is taken.
//  - Throughput: one request per cycle while out_stall_i is low; the frame
//    state updates as a request leaves the input register.
//  - Stall: while out_stall_i holds a result, one more request may sit in the
//    input register; after that in_stall_o rises until the result is taken.
//  - Reset: configuration returns to defaults, frame state and all channel
//    widths clear, both registers empty.
module ppm_frame_decoder_unit #(
  parameter int unsigned NUM_CHANNELS = ppmfd_pkg::NUM_CHANNELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ppmfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ppmfd_pkg::CFG_DAT_W-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ppmfd_pkg::TIME_W-1:0]     edge_time_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ppmfd_pkg::TIME_W-1:0]     pulse_gap_o,
  output logic [ppmfd_pkg::SLOT_W-1:0]     slot_index_o,
  output logic                             slot_written_o,
  output logic                             frame_sync_o,
  output logic                             ready_res_o,
  output logic [ppmfd_pkg::MODE_W-1:0]     flying_mode_o,
  output logic                             switch_high_o
);

  ppmfd_pkg::cfg_t       cfg;
  ppmfd_pkg::frame_res_t res;
  ppmfd_pkg::mode_e      mode;
  logic [ppmfd_pkg::TIME_W-1:0] ch_mode, ch_switch;
  logic                  sw_high;

  logic                         s1_valid_q, s1_valid_d;
  logic [ppmfd_pkg::TIME_W-1:0] edge_q;
  logic                         out_valid_q, out_valid_d;
  logic                         in_acc, s1_fire;

  ppmfd_pkg::frame_res_t        res_q;
  logic [ppmfd_pkg::MODE_W-1:0] mode_q;
  logic                         sw_high_q;

  ppmfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ppmfd_frame_core #(.NUM_CHANNELS(NUM_CHANNELS)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_fire),
    .edge_time_i (edge_q),
    .cfg_i       (cfg),
    .res_o       (res),
    .ch_mode_o   (ch_mode),
    .ch_switch_o (ch_switch)
  );

  ppmfd_chan_decode u_dec (
    .ch_mode_i     (ch_mode),
    .ch_switch_i   (ch_switch),
    .cfg_i         (cfg),
    .mode_o        (mode),
    .switch_high_o (sw_high)
  );

  // Input register moves on whenever the result register is free or draining.
  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc)       s1_valid_d = 1'b1;
    else if (s1_fire) s1_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (s1_fire)                         out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) edge_q <= edge_time_i;
    if (s1_fire) begin
      res_q     <= res;
      mode_q    <= mode;
      sw_high_q <= sw_high;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pulse_gap_o    = res_q.pulse_gap;
  assign slot_index_o   = res_q.slot_index;
  assign slot_written_o = res_q.slot_written;
  assign frame_sync_o   = res_q.frame_sync;
  assign ready_res_o    = res_q.ready;
  assign flying_mode_o  = mode_q;
  assign switch_high_o  = sw_high_q;

endmodule

@@ src/ppmfd_checker.sv @@
// Port-level checks for the PPM frame decoder, bound to the top level.
module ppmfd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [ppmfd_pkg::TIME_W-1:0]  pulse_gap_o,
  input logic [ppmfd_pkg::SLOT_W-1:0]  slot_index_o,
  input logic                          slot_written_o,
  input logic                          frame_sync_o,
  input logic                          ready_res_o
);

  logic seen_ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_ready_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && ready_res_o) begin
      seen_ready_q <= 1'b1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pulse_gap_o))
    else $error("stalled result changed");

  a_sync_no_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_sync_o |-> !slot_written_o)
    else $error("sync gap also stored in a slot");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !slot_written_o |-> slot_index_o == '0)
    else $error("slot index nonzero with no store");

  a_ready_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && seen_ready_q |-> ready_res_o)
    else $error("ready flag dropped");

endmodule

bind ppm_frame_decoder_unit ppmfd_checker u_ppmfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .pulse_gap_o    (pulse_gap_o),
  .slot_index_o   (slot_index_o),
  .slot_written_o (slot_written_o),
  .frame_sync_o   (frame_sync_o),
  .ready_res_o    (ready_res_o)
);
